FILE: rtl/tha_pkg.sv
// ----------------------------------------------------------------------------
// tha_pkg: shared types and constants of the temperature history averager
// Field widths, conversion constants, display mode decode and sequencer states.
// ----------------------------------------------------------------------------
package tha_pkg;

    // default ring depths
    localparam int unsigned HOUR_DEPTH_DEF = 168;
    localparam int unsigned WEEK_DEPTH_DEF = 52;

    // field widths
    localparam int unsigned TEMP_W  = 15;
    localparam int unsigned VALUE_W = 17;
    localparam int unsigned MODE_W  = 4;
    localparam int unsigned UNIT_W  = 2;
    // width of 9*c + 16000 for any 15-bit c
    localparam int unsigned CONV_W  = 20;

    // unit conversion constants, hundredths
    localparam int unsigned KELVIN_OFS = 27315;
    localparam int unsigned FAHR_OFS   = 16000;
    localparam int unsigned FAHR_DIV   = 5;
    localparam int unsigned N_UNITS    = 3;

    typedef enum logic [UNIT_W-1:0] {
        UNIT_C = 2'd0,
        UNIT_F = 2'd1,
        UNIT_K = 2'd2
    } t_unit;

    typedef enum logic [1:0] {
        PER_CURRENT = 2'd0,
        PER_WEEK    = 2'd1,
        PER_YEAR    = 2'd2
    } t_period;

    typedef struct packed {
        logic    ok;
        t_period period;
        t_unit   unit;
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_PUSH,
        S_MEAN,
        S_CONV,
        S_FDIV,
        S_OUT
    } t_state;

    // mode = 3*period + unit, codes past the last period are unused
    function automatic t_mode decode_mode(input logic [MODE_W-1:0] m);
        t_mode d;
        d.ok     = 1'b1;
        d.period = PER_CURRENT;
        d.unit   = UNIT_C;
        if (m < MODE_W'(N_UNITS)) begin
            d.unit = t_unit'(m[UNIT_W-1:0]);
        end else if (m < MODE_W'(2 * N_UNITS)) begin
            d.period = PER_WEEK;
            d.unit   = t_unit'(UNIT_W'(m - MODE_W'(N_UNITS)));
        end else if (m < MODE_W'(3 * N_UNITS)) begin
            d.period = PER_YEAR;
            d.unit   = t_unit'(UNIT_W'(m - MODE_W'(2 * N_UNITS)));
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

FILE: rtl/temperature_history_averager.sv
// ----------------------------------------------------------------------------
// temperature_history_averager: hourly / weekly temperature history
// Record words fill an hourly ring with a running sum; every full set of
// HOUR_DEPTH readings pushes the hourly mean into a weekly ring. Show words
// return the current, weekly or yearly value in C, F or K hundredths.
// A record word updates the hourly ring and, when it completes a set, divides
// the hourly sum for the weekly mean; a show word divides for a nonempty mean,
// converts the unit, divides again for Fahrenheit and loads the output word.
// One word is in work at a time; divider width DIV_W = 23 at default depths.
// Reset: synchronous, clears positions, fills, sums and display mode; the
// ring memories are not cleared, unwritten entries are never used.
// ----------------------------------------------------------------------------
module temperature_history_averager #(
    parameter int unsigned HOUR_DEPTH = tha_pkg::HOUR_DEPTH_DEF,
    parameter int unsigned WEEK_DEPTH = tha_pkg::WEEK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tha_pkg::MODE_W-1:0]          i_cfg_display_mode,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic signed [tha_pkg::TEMP_W-1:0]   i_temp_centi,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tha_pkg::VALUE_W-1:0]  o_value_centi,
    output logic [tha_pkg::UNIT_W-1:0]          o_unit_code
);

    localparam int unsigned TW    = tha_pkg::TEMP_W;
    localparam int unsigned VW    = tha_pkg::VALUE_W;
    localparam int unsigned CW    = tha_pkg::CONV_W;
    localparam int unsigned HP_W  = $clog2(HOUR_DEPTH);
    localparam int unsigned HF_W  = $clog2(HOUR_DEPTH + 1);
    localparam int unsigned HS_W  = TW + HF_W;
    localparam int unsigned WP_W  = $clog2(WEEK_DEPTH);
    localparam int unsigned WF_W  = $clog2(WEEK_DEPTH + 1);
    localparam int unsigned WS_W  = TW + WF_W;
    localparam int unsigned DIV_A = (HS_W > WS_W) ? HS_W : WS_W;
    localparam int unsigned DIV_W = (DIV_A > CW) ? DIV_A : CW;
    localparam int unsigned DEN_A = (HF_W > WF_W) ? HF_W : WF_W;
    localparam int unsigned DEN_W = (DEN_A > 3) ? DEN_A : 3;

    tha_pkg::t_state r_state, n_state;

    logic [tha_pkg::MODE_W-1:0] r_mode;
    tha_pkg::t_mode             w_mode;

    logic signed [TW-1:0]   r_temp;
    logic signed [TW-1:0]   r_c;
    tha_pkg::t_unit         r_res_unit;
    logic signed [VW-1:0]   r_res;

    logic [HP_W-1:0]        r_hour_pos;
    logic [HF_W-1:0]        r_hour_fill;
    logic signed [HS_W-1:0] r_hour_sum;
    logic [HP_W-1:0]        r_hsp;
    logic [WP_W-1:0]        r_week_pos;
    logic [WF_W-1:0]        r_week_fill;
    logic signed [WS_W-1:0] r_week_sum;

    logic signed [TW-1:0]   r_hour_mem [HOUR_DEPTH];
    logic signed [TW-1:0]   r_week_mem [WEEK_DEPTH];
    logic signed [TW-1:0]   r_hour_rd;
    logic signed [TW-1:0]   r_week_rd;

    logic                    r_div_start;
    logic signed [DIV_W-1:0] r_div_num;
    logic [DEN_W-1:0]        r_div_den;
    logic                    w_div_done;
    logic signed [DIV_W-1:0] w_div_quot;
    logic signed [TW-1:0]    w_mean;

    logic                    r_out_valid;
    logic signed [VW-1:0]    r_out_value;
    tha_pkg::t_unit          r_out_unit;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_hour_full;
    logic                    w_week_full;
    logic                    w_push_due;
    logic                    w_mean_empty;
    logic                    w_hour_we;
    logic                    w_week_we;
    logic                    w_out_ld;
    logic signed [HS_W-1:0]  n_hour_sum;
    logic signed [WS_W-1:0]  n_week_sum;
    logic signed [CW-1:0]    w_c_ext;
    logic signed [CW-1:0]    w_fahr_num;

    // shared status
    always_comb begin
        w_mode       = tha_pkg::decode_mode(r_mode);
        w_in_acc     = i_in_valid && o_in_ready;
        w_out_free   = !r_out_valid || i_out_ready;
        w_hour_full  = (r_hour_fill == HF_W'(HOUR_DEPTH));
        w_week_full  = (r_week_fill == WF_W'(WEEK_DEPTH));
        w_push_due   = (r_hsp == HP_W'(HOUR_DEPTH - 1));
        w_mean_empty = (w_mode.period == tha_pkg::PER_WEEK) ? (r_hour_fill == '0)
                                                             : (r_week_fill == '0);
        w_mean       = w_div_quot[TW-1:0];
        n_hour_sum   = r_hour_sum + HS_W'(r_temp)
                       - (w_hour_full ? HS_W'(r_hour_rd) : HS_W'(0));
        n_week_sum   = r_week_sum + WS_W'(w_mean)
                       - (w_week_full ? WS_W'(r_week_rd) : WS_W'(0));
        w_c_ext      = CW'(r_c);
        w_fahr_num   = (w_c_ext <<< 3) + w_c_ext + CW'(tha_pkg::FAHR_OFS);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tha_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (!i_op) begin
                        n_state = tha_pkg::S_REC;
                    end else if (!w_mode.ok) begin
                        n_state = tha_pkg::S_OUT;
                    end else if (w_mode.period == tha_pkg::PER_CURRENT || w_mean_empty) begin
                        n_state = tha_pkg::S_CONV;
                    end else begin
                        n_state = tha_pkg::S_MEAN;
                    end
                end
            end
            tha_pkg::S_REC: begin
                n_state = w_push_due ? tha_pkg::S_PUSH : tha_pkg::S_IDLE;
            end
            tha_pkg::S_PUSH: begin
                if (w_div_done) begin
                    n_state = tha_pkg::S_IDLE;
                end
            end
            tha_pkg::S_MEAN: begin
                if (w_div_done) begin
                    n_state = tha_pkg::S_CONV;
                end
            end
            tha_pkg::S_CONV: begin
                n_state = (r_res_unit == tha_pkg::UNIT_F) ? tha_pkg::S_FDIV : tha_pkg::S_OUT;
            end
            tha_pkg::S_FDIV: begin
                if (w_div_done) begin
                    n_state = tha_pkg::S_OUT;
                end
            end
            tha_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = tha_pkg::S_IDLE;
                end
            end
            default: n_state = tha_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = (r_state == tha_pkg::S_IDLE);
        w_hour_we  = (r_state == tha_pkg::S_REC);
        w_week_we  = (r_state == tha_pkg::S_PUSH) && w_div_done;
        w_out_ld   = (r_state == tha_pkg::S_OUT) && w_out_free;
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tha_pkg::S_IDLE;
            r_mode      <= '0;
            r_hour_pos  <= '0;
            r_hour_fill <= '0;
            r_hour_sum  <= '0;
            r_hsp       <= '0;
            r_week_pos  <= '0;
            r_week_fill <= '0;
            r_week_sum  <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == tha_pkg::S_IDLE && n_state == tha_pkg::S_MEAN)
                        || (r_state == tha_pkg::S_REC  && n_state == tha_pkg::S_PUSH)
                        || (r_state == tha_pkg::S_CONV && n_state == tha_pkg::S_FDIV);
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_display_mode;
            end
            // hourly ring bookkeeping
            if (w_hour_we) begin
                r_hour_sum <= n_hour_sum;
                r_hour_pos <= (r_hour_pos == HP_W'(HOUR_DEPTH - 1)) ? '0
                                                                    : r_hour_pos + HP_W'(1);
                if (!w_hour_full) begin
                    r_hour_fill <= r_hour_fill + HF_W'(1);
                end
                r_hsp <= w_push_due ? '0 : r_hsp + HP_W'(1);
            end
            // weekly ring bookkeeping
            if (w_week_we) begin
                r_week_sum <= n_week_sum;
                r_week_pos <= (r_week_pos == WP_W'(WEEK_DEPTH - 1)) ? '0
                                                                    : r_week_pos + WP_W'(1);
                if (!w_week_full) begin
                    r_week_fill <= r_week_fill + WF_W'(1);
                end
            end
            // output register
            if (w_out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            tha_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_temp     <= i_temp_centi;
                    r_c        <= (w_mode.period == tha_pkg::PER_CURRENT) ? i_temp_centi
                                                                         : '0;
                    r_res_unit <= w_mode.ok ? w_mode.unit : tha_pkg::UNIT_C;
                    r_res      <= '0;
                    if (w_mode.period == tha_pkg::PER_WEEK) begin
                        r_div_num <= DIV_W'(r_hour_sum);
                        r_div_den <= DEN_W'(r_hour_fill);
                    end else begin
                        r_div_num <= DIV_W'(r_week_sum);
                        r_div_den <= DEN_W'(r_week_fill);
                    end
                end
            end
            tha_pkg::S_REC: begin
                r_div_num <= DIV_W'(n_hour_sum);
                r_div_den <= DEN_W'(HOUR_DEPTH);
            end
            tha_pkg::S_MEAN: begin
                if (w_div_done) begin
                    r_c <= w_mean;
                end
            end
            tha_pkg::S_CONV: begin
                r_div_num <= DIV_W'(w_fahr_num);
                r_div_den <= DEN_W'(tha_pkg::FAHR_DIV);
                if (r_res_unit == tha_pkg::UNIT_K) begin
                    r_res <= VW'(r_c) + VW'(tha_pkg::KELVIN_OFS);
                end else begin
                    r_res <= VW'(r_c);
                end
            end
            tha_pkg::S_FDIV: begin
                if (w_div_done) begin
                    r_res <= w_div_quot[VW-1:0];
                end
            end
            default: begin
            end
        endcase
        if (w_out_ld) begin
            r_out_value <= r_res;
            r_out_unit  <= r_res_unit;
        end
    end

    // hourly ring memory, read port follows the write position
    always_ff @(posedge i_clk) begin
        if (w_hour_we) begin
            r_hour_mem[r_hour_pos] <= r_temp;
        end
        r_hour_rd <= r_hour_mem[r_hour_pos];
    end

    // weekly ring memory
    always_ff @(posedge i_clk) begin
        if (w_week_we) begin
            r_week_mem[r_week_pos] <= w_mean;
        end
        r_week_rd <= r_week_mem[r_week_pos];
    end

    // shared serial divider for means and the Fahrenheit scaling
    tha_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_value_centi = r_out_value;
    assign o_unit_code   = r_out_unit;

    // divider finishes only while a state waits on it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == tha_pkg::S_PUSH || r_state == tha_pkg::S_MEAN
                        || r_state == tha_pkg::S_FDIV))
        else $error("divider done outside a waiting state");

    // fills never pass their ring depths
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hour_fill <= HF_W'(HOUR_DEPTH)) && (r_week_fill <= WF_W'(WEEK_DEPTH)))
        else $error("ring fill out of range");

    // a push happens only with a reading that leaves the hourly ring full
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tha_pkg::S_REC && w_push_due) |-> (r_hour_fill >= HF_W'(HOUR_DEPTH - 1)))
        else $error("weekly push before the hourly ring filled");

    // a record word always goes to the ring update next
    a_rec_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_op) |=> (r_state == tha_pkg::S_REC))
        else $error("record word not followed by ring update");

endmodule

FILE: rtl/tha_div.sv
// ----------------------------------------------------------------------------
// tha_div: bit-serial signed divider
// Restoring division of a signed dividend by an unsigned nonzero divisor,
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tha_div #(
    parameter int unsigned NUM_W = 23,
    parameter int unsigned DEN_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    localparam int unsigned CNT_W = (NUM_W > 2) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_acc;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   w_rem_sh;
    logic             w_ge;
    logic [DEN_W:0]   w_rem_sub;
    logic             w_last;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        w_rem_sh  = {r_rem, r_acc[NUM_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub = w_rem_sh - {1'b0, r_den};
        w_last    = (r_cnt == CNT_W'(NUM_W - 1));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // dividend / quotient shift register and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_acc <= i_num[NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= {r_acc[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_acc) : $signed(r_acc);

endmodule

FILE: tb/tha_tb_pkg.sv
// ----------------------------------------------------------------------------
// tha_tb_pkg: verification codes for the temperature history averager
// Word operation codes and display mode helpers used by the testbench top
// and by the history checker.
// ----------------------------------------------------------------------------
package tha_tb_pkg;

    import tha_pkg::*;

    // what an input word asks for
    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_SHOW   = 1'b1
    } t_word_op;

    // first display mode past the last period, and the top code of the field
    localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = MODE_W'(3 * N_UNITS);
    localparam logic [MODE_W-1:0] MODE_ALL_ONES     = '1;

    // mode = 3*period + unit
    function automatic logic [MODE_W-1:0] mode_of(input t_period p, input t_unit u);
        return MODE_W'(N_UNITS * p + u);
    endfunction

endpackage

FILE: tb/tha_history_checker.sv
// ----------------------------------------------------------------------------
// tha_history_checker: display value checker for the temperature averager
// Watches the config, input and result channels, keeps its own hourly and
// weekly history, predicts each display word and compares it field by field.
// ----------------------------------------------------------------------------
module tha_history_checker
    import tha_pkg::*;
    import tha_tb_pkg::*;
#(
    parameter int unsigned HOUR_DEPTH = HOUR_DEPTH_DEF,
    parameter int unsigned WEEK_DEPTH = WEEK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [MODE_W-1:0]          i_cfg_display_mode,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_op,
    input  logic signed [TEMP_W-1:0]   i_temp_centi,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [VALUE_W-1:0]  i_value_centi,
    input  logic [UNIT_W-1:0]          i_unit_code,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FAHR_MUL   = 9;
    localparam int     PRINT_CAP  = 50;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        t_unit                     unit;
    } t_display;

    // predicted history
    logic signed [TEMP_W-1:0] hour_log [HOUR_DEPTH];
    int unsigned              hour_wr;
    int unsigned              hour_held;
    int unsigned              readings_since_push;
    longint                   hour_total;
    logic signed [TEMP_W-1:0] week_log [WEEK_DEPTH];
    int unsigned              week_wr;
    int unsigned              week_held;
    logic [MODE_W-1:0]        mode_now;

    t_display                 display_q [$];
    int                       fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what);
        if (fail_total < PRINT_CAP) begin
            $display("[%0t ns] display check, mode %0d: %s", $time, mode_now, what);
        end
        fail_total++;
    endtask

    function automatic void clear_history();
        hour_wr             = 0;
        hour_held           = 0;
        readings_since_push = 0;
        hour_total          = 0;
        week_wr             = 0;
        week_held           = 0;
        mode_now            = '0;
        display_q.delete();
    endfunction

    function automatic longint mean_of(input longint total, input int unsigned n);
        return (n == 0) ? 0 : total / longint'(n);
    endfunction

    // record word: hourly ring with running sum, weekly push per full set
    function automatic void log_reading(input logic signed [TEMP_W-1:0] t);
        if (hour_held >= HOUR_DEPTH) begin
            hour_total -= hour_log[hour_wr];
        end else begin
            hour_held++;
        end
        hour_log[hour_wr] = t;
        hour_total += t;
        hour_wr = (hour_wr + 1) % HOUR_DEPTH;
        readings_since_push++;
        if (readings_since_push >= HOUR_DEPTH) begin
            readings_since_push = 0;
            week_log[week_wr] = TEMP_W'(hour_total / longint'(HOUR_DEPTH));
            week_wr = (week_wr + 1) % WEEK_DEPTH;
            if (week_held < WEEK_DEPTH) begin
                week_held++;
            end
        end
    endfunction

    // show word: pick the period, then convert to the unit
    function automatic t_display display_for(input logic signed [TEMP_W-1:0] t);
        t_display    d;
        longint      c;
        longint      week_total;
        int unsigned per;
        int unsigned unit;
        int unsigned k;
        d.value = '0;
        d.unit  = UNIT_C;
        if (mode_now >= MODE_FIRST_UNUSED) begin
            return d;
        end
        per  = mode_now / N_UNITS;
        unit = mode_now % N_UNITS;
        case (t_period'(per))
            PER_CURRENT: c = t;
            PER_WEEK:    c = mean_of(hour_total, hour_held);
            default: begin
                week_total = 0;
                for (k = 0; k < week_held; k++) begin
                    week_total += week_log[k];
                end
                c = mean_of(week_total, week_held);
            end
        endcase
        case (t_unit'(unit))
            UNIT_F:  c = (c * FAHR_MUL + longint'(FAHR_OFS)) / longint'(FAHR_DIV);
            UNIT_K:  c = c + longint'(KELVIN_OFS);
            default: ;
        endcase
        d.value = c[VALUE_W-1:0];
        d.unit  = t_unit'(unit[UNIT_W-1:0]);
        return d;
    endfunction

    // sample every channel at the clock edge, results before new words,
    // a mode write takes effect after the word accepted with it
    always @(posedge i_clk) begin
        t_display want;
        if (!i_rst_n) begin
            clear_history();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (display_q.size() == 0) begin
                    report_mismatch($sformatf("word %0d / unit %0d with nothing expected",
                                              i_value_centi, i_unit_code));
                end else begin
                    want = display_q.pop_front();
                    if (i_value_centi !== want.value) begin
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  i_value_centi, want.value));
                    end
                    if (i_unit_code !== want.unit) begin
                        report_mismatch($sformatf("unit %0d, expected %0d",
                                                  i_unit_code, want.unit));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_SHOW) begin
                    display_q.push_back(display_for(i_temp_centi));
                end else begin
                    log_reading(i_temp_centi);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                mode_now = i_cfg_display_mode;
            end
        end
        o_pending <= display_q.size();
    end

endmodule

FILE: tb/tb_temperature_history_averager.sv
// ----------------------------------------------------------------------------
// tb_temperature_history_averager: testbench of the temperature averager
// Directed words for empty means, unused modes, unit conversions and
// temperature extremes, then random phases over every display mode with
// random idling on both channels, full-scale reading bursts and a stretch
// without idling. A checker beside the block predicts every display word.
// ----------------------------------------------------------------------------
module tb_temperature_history_averager
    import tha_pkg::*;
    import tha_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOUR_D       = HOUR_DEPTH_DEF;
    localparam int unsigned WEEK_D       = WEEK_DEPTH_DEF;
    localparam int unsigned SETTLE       = 64;
    localparam int unsigned PHASES       = 16;
    localparam int unsigned PHASE_WORDS  = 80;
    localparam int unsigned CALM_PHASE   = 9;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    logic                       i_clk              = 1'b0;
    logic                       i_rst_n            = 1'b0;
    logic                       i_cfg_valid        = 1'b0;
    logic [MODE_W-1:0]          i_cfg_display_mode = '0;
    logic                       i_in_valid         = 1'b0;
    logic                       i_op               = 1'b0;
    logic signed [TEMP_W-1:0]   i_temp_centi       = '0;
    logic                       i_out_ready        = 1'b0;
    logic                       o_cfg_ready;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic signed [VALUE_W-1:0]  o_value_centi;
    logic [UNIT_W-1:0]          o_unit_code;

    bit calm = 1'b0;
    int fail_count;
    int pending;
    int n_records = 0;
    int n_shows   = 0;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    temperature_history_averager #(
        .HOUR_DEPTH (HOUR_D),
        .WEEK_DEPTH (WEEK_D)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_display_mode (i_cfg_display_mode),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_temp_centi       (i_temp_centi),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_value_centi      (o_value_centi),
        .o_unit_code        (o_unit_code)
    );

    tha_history_checker #(
        .HOUR_DEPTH (HOUR_D),
        .WEEK_DEPTH (WEEK_D)
    ) u_history_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_display_mode (i_cfg_display_mode),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_temp_centi       (i_temp_centi),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_value_centi      (o_value_centi),
        .i_unit_code        (o_unit_code),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // result side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 18);
    end

    // half typical readings, some raw 15-bit patterns, some corner values
    function automatic logic signed [TEMP_W-1:0] draw_temp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return TEMP_W'(int'($urandom_range(20000)) - 10000);
        end
        if (pick < 80) begin
            return TEMP_W'($urandom);
        end
        case ($urandom_range(3))
            0:       return TEMP_MAX;
            1:       return TEMP_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // one input word, with an optional gap before it
    task automatic send_word(input t_word_op op, input logic signed [TEMP_W-1:0] t);
        int unsigned gap;
        gap = 0;
        if (!calm) begin
            if ($urandom_range(99) < 4) begin
                gap = $urandom_range(40, 1);
            end else if ($urandom_range(99) < 25) begin
                gap = $urandom_range(3, 1);
            end
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_temp_centi <= t;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_SHOW) begin
            n_shows++;
        end else begin
            n_records++;
        end
    endtask

    // wait for every display word, then for a weekly push still in work
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        drain_and_settle();
        i_cfg_valid        <= 1'b1;
        i_cfg_display_mode <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [MODE_W-1:0] mode;
        int unsigned       n;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty means in two units, then the unused modes
        set_mode(mode_of(PER_WEEK, UNIT_C));
        send_word(OP_SHOW, '0);
        set_mode(mode_of(PER_YEAR, UNIT_F));
        send_word(OP_SHOW, '1);
        set_mode(MODE_ALL_ONES);
        send_word(OP_SHOW, TEMP_MAX);
        set_mode(MODE_FIRST_UNUSED);
        send_word(OP_SHOW, TEMP_MIN);

        // current temperature at the extremes in every unit
        set_mode(mode_of(PER_CURRENT, UNIT_C));
        send_word(OP_SHOW, TEMP_MAX);
        send_word(OP_SHOW, TEMP_MIN);
        send_word(OP_SHOW, 15'sd10000);
        send_word(OP_SHOW, -15'sd10000);
        send_word(OP_SHOW, '1);
        set_mode(mode_of(PER_CURRENT, UNIT_F));
        send_word(OP_SHOW, TEMP_MAX);
        send_word(OP_SHOW, TEMP_MIN);
        send_word(OP_SHOW, '1);
        // fahrenheit numerator of -2 truncates toward zero
        send_word(OP_SHOW, -15'sd1778);
        set_mode(mode_of(PER_CURRENT, UNIT_K));
        send_word(OP_SHOW, TEMP_MAX);
        send_word(OP_SHOW, TEMP_MIN);

        // hourly mean over a few readings, negative sum truncates toward zero
        set_mode(mode_of(PER_WEEK, UNIT_F));
        send_word(OP_RECORD, TEMP_MAX);
        send_word(OP_RECORD, TEMP_MIN);
        send_word(OP_RECORD, 15'sd5);
        send_word(OP_SHOW, '0);
        send_word(OP_RECORD, -15'sd7);
        send_word(OP_SHOW, '0);

        // random phases, one display mode each, all sixteen codes in turn
        for (int unsigned p = 0; p < PHASES; p++) begin
            mode = MODE_W'(p * 7);
            set_mode(mode);
            calm <= (p == CALM_PHASE);
            // a full set of extreme readings drives the running sum to its limits
            if (mode == mode_of(PER_WEEK, UNIT_C) || mode == mode_of(PER_WEEK, UNIT_K)) begin
                for (n = 0; n < HOUR_D; n++) begin
                    send_word(OP_RECORD, (mode == mode_of(PER_WEEK, UNIT_C)) ? TEMP_MAX
                                                                             : TEMP_MIN);
                end
                send_word(OP_SHOW, draw_temp());
            end
            for (n = 0; n < PHASE_WORDS; n++) begin
                send_word(($urandom_range(99) < 25) ? OP_SHOW : OP_RECORD, draw_temp());
            end
        end
        calm <= 1'b0;

        drain_and_settle();
        $display("covered %0d readings and %0d display requests over all %0d display modes,",
                 n_records, n_shows, 2 ** MODE_W);
        $display("with extreme reading sets, %0d weekly pushes and random idling on both sides",
                 n_records / HOUR_D);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("watchdog expired with %0d display words outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
